// ----- rtl/core/tcgr_pkg.sv -----
`default_nettype none

package tcgr_pkg;

  // Character codes with special handling
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] END_CODE     = 8'd128;

  // Glyph geometry
  localparam int GLYPH_W       = 6;
  localparam int GLYPH_H       = 8;
  localparam int GLYPH_COUNT   = 96;
  localparam int PIX_PER_GLYPH = GLYPH_W * GLYPH_H;
  localparam int GLYPH_BITS    = PIX_PER_GLYPH;
  localparam int GLYPH_IDX_W   = 7;
  localparam int PIX_CNT_W     = 6;
  localparam logic [PIX_CNT_W-1:0] PIX_LAST = PIX_CNT_W'(PIX_PER_GLYPH - 1);

  // Field widths
  localparam int CODE_W  = 8;
  localparam int COLOR_W = 16;
  localparam int PX_W    = 7;
  localparam int PY_W    = 6;
  // wide enough for 63 * 6 + 5 before truncation
  localparam int POS_W   = 9;

  // Grid defaults
  localparam int TEXT_COLUMNS_DEF = 16;
  localparam int TEXT_ROWS_DEF    = 8;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } tcgr_state_t;

  // Cursor update request from the sequencer
  typedef struct packed {
    logic adv_col;
    logic new_line;
  } tcgr_cur_cmd_t;

  // Font: one 48-bit word per glyph, byte n is glyph column n, bit 0 the top row
  localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h0000005F0000, 48'h000003040304, 48'h000A3F147E28,
    48'h00122A7F2A24, 48'h006264081323, 48'h005026594E30, 48'h000001020000,
    48'h0041221C0000, 48'h0000001C2241, 48'h002214081422, 48'h0008083E0808,
    48'h000000003050, 48'h000808080808, 48'h000000006060, 48'h000204081020,
    48'h003E4549513E, 48'h0000407F4200, 48'h004649495162, 48'h003649494122,
    48'h00107F121418, 48'h00394545452F, 48'h00324949493E, 48'h000305196101,
    48'h003649494936, 48'h003E49494926, 48'h000000363600, 48'h000000365600,
    48'h004122140800, 48'h001414141414, 48'h000008142241, 48'h000609590102,
    48'h002E555D413E, 48'h00601C131C60, 48'h00364949497F, 48'h00224141413E,
    48'h001C2241417F, 48'h00414949497F, 48'h00010909097F, 48'h003A4941221C,
    48'h007F0808087F, 48'h0000417F4100, 48'h003F40404020, 48'h00412214087F,
    48'h00004040407F, 48'h007F0418047F, 48'h007F1008047F, 48'h003E4141413E,
    48'h00060909097F, 48'h005E2151413E, 48'h00462919097F, 48'h003249494926,
    48'h0001017F0101, 48'h003F4040403F, 48'h00031C601C03, 48'h000F700F700F,
    48'h004136083641, 48'h000102780601, 48'h004345495161, 48'h0041417F0000,
    48'h0011167C1615, 48'h0000007F4141, 48'h000002010200, 48'h004040404040,
    48'h000000020100, 48'h007854542000, 48'h003844447F00, 48'h002844443800,
    48'h007F44443800, 48'h001854543800, 48'h0001053E0400, 48'h003C54540800,
    48'h007804047F00, 48'h0000007D0000, 48'h00003D404000, 48'h004428107F00,
    48'h0000007F0100, 48'h0078047C047C, 48'h007804047C00, 48'h003844443800,
    48'h000814147C00, 48'h007C14140800, 48'h000404087C00, 48'h002454544800,
    48'h0040443E0400, 48'h007C40403C00, 48'h000C10207C00, 48'h001C601C601C,
    48'h006C10106C00, 48'h001C30504C00, 48'h004C54644400, 48'h004141360800,
    48'h0000007F0000, 48'h000008364141, 48'h000810080408, 48'h000000000000
  };

  // Glyph for a character code; codes without a font entry draw blank
  function automatic logic [GLYPH_BITS-1:0] font_lookup(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]      off;
    logic [GLYPH_BITS-1:0]  word;
    off  = code - FIRST_CODE;
    word = '0;
    if (code >= FIRST_CODE && code < END_CODE) begin
      word = FONT_ROM[off[GLYPH_IDX_W-1:0]];
    end
    return word;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcgr_in_if.sv -----
`default_nettype none

interface tcgr_in_if
  import tcgr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic [COLOR_W-1:0] fg_color;

  modport source (output valid, output char_code, output fg_color, input ready);
  modport sink   (input valid, input char_code, input fg_color, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcgr_out_if.sv -----
`default_nettype none

interface tcgr_out_if
  import tcgr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PX_W-1:0]    pixel_x;
  logic [PY_W-1:0]    pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcgr_cursor.sv -----
`default_nettype none

module tcgr_cursor
  import tcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
  localparam int COL_W = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1,
  localparam int ROW_W = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tcgr_cur_cmd_t  cmd,
  output logic [COL_W-1:0]    col,
  output logic [ROW_W-1:0]    row
);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TEXT_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TEXT_ROWS - 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] row_inc;

  // next row with wrap to the top
  assign row_inc = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;

  // newline or column wrap moves to the start of the next row
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.new_line) begin
      col_nxt = '0;
      row_nxt = row_inc;
    end else if (cmd.adv_col) begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

endmodule

`default_nettype wire

// ----- rtl/core/text_cell_glyph_renderer_top.sv -----
`default_nettype none

// Text cell glyph renderer. Each input transfer carries a character code and a
// foreground color and moves a text cursor over a TEXT_COLUMNS x TEXT_ROWS grid.
// Newline and space only move the cursor. Any other code draws a 6x8 cell from
// the built-in font (codes outside 32..127 draw blank): 48 pixel transfers,
// column by column, top to bottom within a column, the last one flagged by
// last_pixel. The input is held off while a cell is drawn. The pixel sequencer
// sends one pixel per cycle unless the output stalls, through a single shared
// position incrementer. Pixel coordinates are cursor_col*6 + glyph column
// and cursor_row*8 + glyph row, truncated to 7 and 6 bits.
module text_cell_glyph_renderer_top
  import tcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcgr_in_if.sink    in_ch,
  tcgr_out_if.source out_ch
);

  localparam int COL_W = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
  localparam int ROW_W = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  tcgr_state_t            state_r, state_nxt;
  logic [GLYPH_BITS-1:0]  glyph_r, glyph_nxt;
  logic [COLOR_W-1:0]     color_r, color_nxt;
  logic [PX_W-1:0]        px_r, px_nxt;
  logic [PY_W-1:0]        py_r, py_nxt;
  logic [PIX_CNT_W-1:0]   cnt_r, cnt_nxt;

  tcgr_cur_cmd_t          cur_cmd;
  logic [COL_W-1:0]       cur_col;
  logic [ROW_W-1:0]       cur_row;
  logic [POS_W-1:0]       col_ext, row_ext;
  logic [PX_W-1:0]        x_base;
  logic [PY_W-1:0]        y_base;
  logic                   in_xfer, out_xfer, col_end;
  logic [PX_W-1:0]        inc_a, inc_y;

  // Cursor state
  tcgr_cursor #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cur_cmd),
    .col   (cur_col),
    .row   (cur_row)
  );

  // Cell origin in pixels: col*6 and row*8, truncated
  assign col_ext = POS_W'(cur_col);
  assign row_ext = POS_W'(cur_row);
  assign x_base  = PX_W'((col_ext << 2) + (col_ext << 1));
  assign y_base  = PY_W'(row_ext << 3);

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign col_end  = (cnt_r[2:0] == 3'd7);

  // Shared incrementer: x at the end of a glyph column, else y
  assign inc_a = col_end ? px_r : PX_W'(py_r);
  assign inc_y = inc_a + 1'b1;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    glyph_nxt = glyph_r;
    color_nxt = color_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    cnt_nxt   = cnt_r;
    cur_cmd   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.char_code == CODE_NEWLINE) begin
            cur_cmd.new_line = 1'b1;
          end else if (in_ch.char_code == CODE_SPACE) begin
            cur_cmd.adv_col = 1'b1;
          end else begin
            glyph_nxt = font_lookup(in_ch.char_code);
            color_nxt = in_ch.fg_color;
            px_nxt    = x_base;
            py_nxt    = y_base;
            cnt_nxt   = '0;
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (out_xfer) begin
          glyph_nxt = glyph_r >> 1;
          cnt_nxt   = cnt_r + 1'b1;
          if (col_end) begin
            px_nxt = inc_y;
            py_nxt = y_base;
          end else begin
            py_nxt = inc_y[PY_W-1:0];
          end
          if (cnt_r == PIX_LAST) begin
            cur_cmd.adv_col = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    color_r <= color_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
  end

  // Channel outputs
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_DRAW);
  assign out_ch.pixel_x     = px_r;
  assign out_ch.pixel_y     = py_r;
  assign out_ch.pixel_color = glyph_r[0] ? color_r : '0;
  assign out_ch.last_pixel  = (cnt_r == PIX_LAST);

`ifndef SYNTHESIS
  // never take a character while a cell is being drawn
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while drawing");

  // last pixel transfer returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_pixel) |=> in_ch.ready)
    else $error("not idle after last pixel");

  // a drawn cell starts at its top row, glyph column 0
  a_cell_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.char_code != CODE_NEWLINE &&
     in_ch.char_code != CODE_SPACE)
    |=> (out_ch.valid && out_ch.pixel_y[2:0] == 3'd0 && !out_ch.last_pixel))
    else $error("cell start misplaced");

  // newline and space produce no pixels
  a_ctrl_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready &&
     (in_ch.char_code == CODE_NEWLINE || in_ch.char_code == CODE_SPACE))
    |=> !out_ch.valid)
    else $error("pixels after control code");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tcgr_pkg::*;

  localparam int GRID_COLS     = TEXT_COLUMNS_DEF;
  localparam int GRID_ROWS     = TEXT_ROWS_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int REPORT_LIMIT  = 10;

  // Font columns, bit 0 is the top glyph row
  localparam logic [7:0] GLYPH_COLS [GLYPH_COUNT][GLYPH_W] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00},
    '{8'h04,8'h03,8'h04,8'h03,8'h00,8'h00}, '{8'h28,8'h7E,8'h14,8'h3F,8'h0A,8'h00},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00}, '{8'h23,8'h13,8'h08,8'h64,8'h62,8'h00},
    '{8'h30,8'h4E,8'h59,8'h26,8'h50,8'h00}, '{8'h00,8'h00,8'h02,8'h01,8'h00,8'h00},
    '{8'h00,8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h41,8'h22,8'h1C,8'h00,8'h00,8'h00},
    '{8'h22,8'h14,8'h08,8'h14,8'h22,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00},
    '{8'h50,8'h30,8'h00,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
    '{8'h60,8'h60,8'h00,8'h00,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02,8'h00},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00}, '{8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00},
    '{8'h62,8'h51,8'h49,8'h49,8'h46,8'h00}, '{8'h22,8'h41,8'h49,8'h49,8'h36,8'h00},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00}, '{8'h2F,8'h45,8'h45,8'h45,8'h39,8'h00},
    '{8'h3E,8'h49,8'h49,8'h49,8'h32,8'h00}, '{8'h01,8'h61,8'h19,8'h05,8'h03,8'h00},
    '{8'h36,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h26,8'h49,8'h49,8'h49,8'h3E,8'h00},
    '{8'h00,8'h36,8'h36,8'h00,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h00},
    '{8'h41,8'h22,8'h14,8'h08,8'h00,8'h00}, '{8'h02,8'h01,8'h59,8'h09,8'h06,8'h00},
    '{8'h3E,8'h41,8'h5D,8'h55,8'h2E,8'h00}, '{8'h60,8'h1C,8'h13,8'h1C,8'h60,8'h00},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00}, '{8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01,8'h00}, '{8'h1C,8'h22,8'h41,8'h49,8'h3A,8'h00},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00}, '{8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00},
    '{8'h20,8'h40,8'h40,8'h40,8'h3F,8'h00}, '{8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00},
    '{8'h7F,8'h40,8'h40,8'h40,8'h00,8'h00}, '{8'h7F,8'h04,8'h18,8'h04,8'h7F,8'h00},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00}, '{8'h26,8'h49,8'h49,8'h49,8'h32,8'h00},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00},
    '{8'h03,8'h1C,8'h60,8'h1C,8'h03,8'h00}, '{8'h0F,8'h70,8'h0F,8'h70,8'h0F,8'h00},
    '{8'h41,8'h36,8'h08,8'h36,8'h41,8'h00}, '{8'h01,8'h06,8'h78,8'h02,8'h01,8'h00},
    '{8'h61,8'h51,8'h49,8'h45,8'h43,8'h00}, '{8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h15,8'h16,8'h7C,8'h16,8'h11,8'h00}, '{8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00},
    '{8'h00,8'h02,8'h01,8'h02,8'h00,8'h00}, '{8'h40,8'h40,8'h40,8'h40,8'h40,8'h00},
    '{8'h00,8'h01,8'h02,8'h00,8'h00,8'h00}, '{8'h00,8'h20,8'h54,8'h54,8'h78,8'h00},
    '{8'h00,8'h7F,8'h44,8'h44,8'h38,8'h00}, '{8'h00,8'h38,8'h44,8'h44,8'h28,8'h00},
    '{8'h00,8'h38,8'h44,8'h44,8'h7F,8'h00}, '{8'h00,8'h38,8'h54,8'h54,8'h18,8'h00},
    '{8'h00,8'h04,8'h3E,8'h05,8'h01,8'h00}, '{8'h00,8'h08,8'h54,8'h54,8'h3C,8'h00},
    '{8'h00,8'h7F,8'h04,8'h04,8'h78,8'h00}, '{8'h00,8'h00,8'h7D,8'h00,8'h00,8'h00},
    '{8'h00,8'h40,8'h40,8'h3D,8'h00,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h01,8'h7F,8'h00,8'h00,8'h00}, '{8'h7C,8'h04,8'h7C,8'h04,8'h78,8'h00},
    '{8'h00,8'h7C,8'h04,8'h04,8'h78,8'h00}, '{8'h00,8'h38,8'h44,8'h44,8'h38,8'h00},
    '{8'h00,8'h7C,8'h14,8'h14,8'h08,8'h00}, '{8'h00,8'h08,8'h14,8'h14,8'h7C,8'h00},
    '{8'h00,8'h7C,8'h08,8'h04,8'h04,8'h00}, '{8'h00,8'h48,8'h54,8'h54,8'h24,8'h00},
    '{8'h00,8'h04,8'h3E,8'h44,8'h40,8'h00}, '{8'h00,8'h3C,8'h40,8'h40,8'h7C,8'h00},
    '{8'h00,8'h7C,8'h20,8'h10,8'h0C,8'h00}, '{8'h1C,8'h60,8'h1C,8'h60,8'h1C,8'h00},
    '{8'h00,8'h6C,8'h10,8'h10,8'h6C,8'h00}, '{8'h00,8'h4C,8'h50,8'h30,8'h1C,8'h00},
    '{8'h00,8'h44,8'h64,8'h54,8'h4C,8'h00}, '{8'h00,8'h08,8'h36,8'h41,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00}, '{8'h41,8'h41,8'h36,8'h08,8'h00,8'h00},
    '{8'h08,8'h04,8'h08,8'h10,8'h08,8'h00}, '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

  typedef struct packed {
    logic [PX_W-1:0]    x;
    logic [PY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // One directed character; blank cells carry their origin typed in by hand
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
    logic               blank_known;
    logic [PX_W-1:0]    org_x;
    logic [PY_W-1:0]    org_y;
  } char_row_t;

  localparam int N_DIRECTED = 21;

  localparam char_row_t DIRECTED_CHARS [N_DIRECTED] = '{
    '{8'd0,         16'hFFFF, 1'b1, 7'd0,  6'd0},  // below font, blank at home
    '{8'd65,        16'hFFFF, 1'b0, 7'd0,  6'd0},  // 'A'
    '{8'd33,        16'h0000, 1'b0, 7'd0,  6'd0},  // first glyph, zero color
    '{8'd127,       16'hFFFF, 1'b1, 7'd18, 6'd0},  // empty font entry
    '{8'd255,       16'hAAAA, 1'b1, 7'd24, 6'd0},  // top code, blank
    '{CODE_SPACE,   16'hFFFF, 1'b0, 7'd0,  6'd0},
    '{8'd126,       16'h5555, 1'b0, 7'd0,  6'd0},  // '~'
    '{CODE_NEWLINE, 16'hFFFF, 1'b0, 7'd0,  6'd0},
    '{8'd11,        16'h1234, 1'b1, 7'd0,  6'd8},  // control code on row 1
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{CODE_NEWLINE, 16'h0000, 1'b0, 7'd0,  6'd0},
    '{8'd87,        16'hFFFF, 1'b0, 7'd0,  6'd0},  // 'W' on the bottom row
    '{CODE_NEWLINE, 16'hFFFF, 1'b0, 7'd0,  6'd0},  // row wraps to 0
    '{8'd90,        16'h8001, 1'b0, 7'd0,  6'd0},  // 'Z'
    '{8'd31,        16'h7FFE, 1'b1, 7'd6,  6'd0},  // just below font
    '{8'd128,       16'hFFFF, 1'b1, 7'd12, 6'd0},  // just above font
    '{8'd64,        16'hC3C3, 1'b0, 7'd0,  6'd0}   // '@'
  };

  logic clk;
  logic rst_n;

  tcgr_in_if  in_ch ();
  tcgr_out_if out_ch ();

  text_cell_glyph_renderer_top #(
    .TEXT_COLUMNS (GRID_COLS),
    .TEXT_ROWS    (GRID_ROWS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pixel_t pending_pixels [$];
  int     text_col;
  int     text_row;
  int     mismatches;
  int     in_gap_pct;
  int     out_stall_pct;
  int     quiet_cycles;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cursor motion
  function automatic void advance_cursor();
    text_col++;
    if (text_col >= GRID_COLS) begin
      text_col = 0;
      text_row++;
    end
    if (text_row >= GRID_ROWS) text_row = 0;
  endfunction

  // Expected pixels of one character, then the cursor update
  function automatic void render_char(input logic [CODE_W-1:0] code,
                                      input logic [COLOR_W-1:0] color);
    logic [7:0] col_bits;
    pixel_t     px;
    int         n;
    n = 0;
    if (code == CODE_NEWLINE) begin
      text_col = 0;
      text_row++;
      if (text_row >= GRID_ROWS) text_row = 0;
    end else if (code == CODE_SPACE) begin
      advance_cursor();
    end else begin
      for (int gx = 0; gx < GLYPH_W; gx++) begin
        col_bits = 8'h00;
        if (code >= FIRST_CODE && code < END_CODE)
          col_bits = GLYPH_COLS[int'(code) - int'(FIRST_CODE)][gx];
        for (int gy = 0; gy < GLYPH_H; gy++) begin
          px.x     = PX_W'(text_col * GLYPH_W + gx);
          px.y     = PY_W'(text_row * GLYPH_H + gy);
          px.color = col_bits[gy] ? color : '0;
          px.last  = (n == PIX_PER_GLYPH - 1);
          pending_pixels.push_back(px);
          n++;
        end
      end
      advance_cursor();
    end
  endfunction

  // One input transfer, entered and left at a falling edge
  task automatic send_char(input char_row_t row);
    pixel_t px;
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= row.code;
    in_ch.fg_color  <= row.color;
    do @(posedge clk); while (!in_ch.ready);
    if (row.blank_known) begin
      for (int n = 0; n < PIX_PER_GLYPH; n++) begin
        px.x     = row.org_x + PX_W'(n / GLYPH_H);
        px.y     = row.org_y + PY_W'(n % GLYPH_H);
        px.color = '0;
        px.last  = (n == PIX_PER_GLYPH - 1);
        pending_pixels.push_back(px);
      end
      advance_cursor();
    end else begin
      render_char(row.code, row.color);
    end
    @(negedge clk);
  endtask

  // Hold the input off until every pixel in flight has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    char_row_t row;
    int        pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 3) wait_drained();
      pick = $urandom_range(99);
      if (pick < 55)
        row.code = CODE_W'($urandom_range(126, 33));
      else if (pick < 67)
        row.code = CODE_SPACE;
      else if (pick < 75)
        row.code = CODE_NEWLINE;
      else if (pick < 87)
        row.code = $urandom_range(1) ? CODE_W'($urandom_range(31, 0))
                                      : CODE_W'($urandom_range(255, 127));
      else
        row.code = CODE_W'($urandom_range(255, 0));
      pick = $urandom_range(99);
      if (pick < 10)
        row.color = '0;
      else if (pick < 20)
        row.color = '1;
      else
        row.color = COLOR_W'($urandom_range(65535, 0));
      row.blank_known = 1'b0;
      row.org_x       = '0;
      row.org_y       = '0;
      send_char(row);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Pixel checker
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    pixel_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last_pixel};
      if (pending_pixels.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected pixel: x=%0d y=%0d color=%h last=%b",
                   seen.x, seen.y, seen.color, seen.last);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (seen.x !== want.x || seen.y !== want.y ||
            seen.color !== want.color || seen.last !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                     want.x, want.y, want.color, want.last,
                     seen.x, seen.y, seen.color, seen.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    text_col        = 0;
    text_row        = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    in_gap_pct      = 38;
    out_stall_pct   = 69;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.fg_color  = '0;
    out_ch.ready    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender gappy, receiver mostly stalled
    for (int i = 0; i < N_DIRECTED; i++) send_char(DIRECTED_CHARS[i]);
    send_random(110);
    wait_drained();

    // roles swapped
    in_gap_pct    = 69;
    out_stall_pct = 38;
    send_random(115);
    wait_drained();

    // full rate
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_random(115);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
